>>> rtl/sbic_pkg.sv
// Shared package of the stack bytecode integer core.
// Opcode codes, status and ALU operation codes, state type, sizes and decode.
// Used by sbic_alu and stack_bytecode_integer_core_unit.
package sbic_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int LOCAL_COUNT = 256;
	localparam int MAX_ARRAYS  = 8;
	localparam int POOL_WORDS  = 1024;

	localparam int SP_W    = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW  = $clog2(STACK_DEPTH);
	localparam int LOC_AW  = $clog2(LOCAL_COUNT);
	localparam int MADE_W  = $clog2(MAX_ARRAYS + 1);
	localparam int AIDX_W  = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
	localparam int PF_W    = $clog2(POOL_WORDS + 1);
	localparam int POOL_AW = $clog2(POOL_WORDS);

	localparam logic [7:0] OP_PUSH_CONST_LO = 8'h02;
	localparam logic [7:0] OP_PUSH_CONST_HI = 8'h08;
	localparam logic [7:0] OP_PUSH_BYTE     = 8'h10;
	localparam logic [7:0] OP_PUSH_SHORT    = 8'h11;
	localparam logic [7:0] OP_LOAD_INT      = 8'h15;
	localparam logic [7:0] OP_LOAD_REF      = 8'h19;
	localparam logic [7:0] OP_LOAD_INT_0    = 8'h1A;
	localparam logic [7:0] OP_LOAD_INT_3    = 8'h1D;
	localparam logic [7:0] OP_LOAD_REF_0    = 8'h2A;
	localparam logic [7:0] OP_LOAD_REF_3    = 8'h2D;
	localparam logic [7:0] OP_ARRAY_LOAD    = 8'h2E;
	localparam logic [7:0] OP_STORE_INT     = 8'h36;
	localparam logic [7:0] OP_STORE_REF     = 8'h3A;
	localparam logic [7:0] OP_STORE_INT_0   = 8'h3B;
	localparam logic [7:0] OP_STORE_INT_3   = 8'h3E;
	localparam logic [7:0] OP_STORE_REF_0   = 8'h4B;
	localparam logic [7:0] OP_STORE_REF_3   = 8'h4E;
	localparam logic [7:0] OP_ARRAY_STORE   = 8'h4F;
	localparam logic [7:0] OP_DUP           = 8'h59;
	localparam logic [7:0] OP_IADD          = 8'h60;
	localparam logic [7:0] OP_ISUB          = 8'h64;
	localparam logic [7:0] OP_IMUL          = 8'h68;
	localparam logic [7:0] OP_IDIV          = 8'h6C;
	localparam logic [7:0] OP_IREM          = 8'h70;
	localparam logic [7:0] OP_IINC          = 8'h84;
	localparam logic [7:0] OP_BRANCH_GE     = 8'hA2;
	localparam logic [7:0] OP_GOTO          = 8'hA7;
	localparam logic [7:0] OP_RETURN        = 8'hB1;
	localparam logic [7:0] OP_NEWARRAY      = 8'hBC;

	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_UNKNOWN   = 3'd1;
	localparam logic [2:0] STS_DIV_ZERO  = 3'd2;
	localparam logic [2:0] STS_STACK     = 3'd3;
	localparam logic [2:0] STS_POOL_FULL = 3'd4;

	typedef enum logic [2:0] {
		ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_REM, ALU_CGE
	} alu_op_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DEC, S_RD1, S_RD2, S_RD3, S_EXEC, S_POOL, S_WB, S_OUT
	} state_t;

	typedef struct packed {
		logic       known;
		logic [1:0] pops;
		logic [1:0] pushes;
		logic [1:0] len;
	} dec_t;

	function automatic dec_t decode(logic [7:0] op);
		dec_t d;
		d = '{known: 1'b1, pops: 2'd0, pushes: 2'd0, len: 2'd1};
		case (op) inside
			[OP_PUSH_CONST_LO:OP_PUSH_CONST_HI]: d.pushes = 2'd1;
			OP_PUSH_BYTE, OP_LOAD_INT, OP_LOAD_REF: begin
				d.pushes = 2'd1;
				d.len = 2'd2;
			end
			OP_PUSH_SHORT: begin
				d.pushes = 2'd1;
				d.len = 2'd3;
			end
			[OP_LOAD_INT_0:OP_LOAD_INT_3], [OP_LOAD_REF_0:OP_LOAD_REF_3]: d.pushes = 2'd1;
			OP_ARRAY_LOAD, OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM: begin
				d.pops = 2'd2;
				d.pushes = 2'd1;
			end
			OP_STORE_INT, OP_STORE_REF: begin
				d.pops = 2'd1;
				d.len = 2'd2;
			end
			[OP_STORE_INT_0:OP_STORE_INT_3], [OP_STORE_REF_0:OP_STORE_REF_3]: d.pops = 2'd1;
			OP_ARRAY_STORE: d.pops = 2'd3;
			OP_DUP: begin
				d.pops = 2'd1;
				d.pushes = 2'd2;
			end
			OP_IINC: d.len = 2'd3;
			OP_BRANCH_GE: begin
				d.pops = 2'd2;
				d.len = 2'd3;
			end
			OP_GOTO, OP_RETURN: d.len = 2'd1;
			OP_NEWARRAY: begin
				d.pops = 2'd1;
				d.pushes = 2'd1;
				d.len = 2'd2;
			end
			default: d.known = 1'b0;
		endcase
		return d;
	endfunction

endpackage

>>> rtl/sbic_alu.sv
// Shared arithmetic unit of the stack bytecode integer core.
// Add, subtract, multiply and compare finish in the cycle after start;
// divide and remainder by a 32-step restoring divider. Depends on sbic_pkg.
module sbic_alu import sbic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  alu_op_t     op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] result
);

	logic        busy_q, done_q, isrem_q, negq_q, negr_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q, quo_q, dvs_q, res_q;
	logic [32:0] sh, diff;
	logic [31:0] rem_n, quo_n;

	always_comb begin
		sh = {rem_q, quo_q[31]};
		diff = sh - {1'b0, dvs_q};
		if (!diff[32]) begin
			rem_n = diff[31:0];
			quo_n = {quo_q[30:0], 1'b1};
		end else begin
			rem_n = sh[31:0];
			quo_n = {quo_q[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if ((op == ALU_DIV || op == ALU_REM) && b != 32'd0) begin
					busy_q <= 1'b1;
				end else begin
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= a[31] ? 32'd0 - a : a;
			dvs_q <= b[31] ? 32'd0 - b : b;
			negq_q <= a[31] ^ b[31];
			negr_q <= a[31];
			isrem_q <= (op == ALU_REM);
			case (op)
				ALU_ADD: res_q <= a + b;
				ALU_SUB: res_q <= a - b;
				ALU_MUL: res_q <= a * b;
				ALU_CGE: res_q <= {31'd0, $signed(a) >= $signed(b)};
				default: res_q <= 32'd0;
			endcase
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
			if (cnt_q == 5'd31) begin
				if (isrem_q) res_q <= negr_q ? 32'd0 - rem_n : rem_n;
				else res_q <= negq_q ? 32'd0 - quo_n : quo_n;
			end
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

>>> rtl/stack_bytecode_integer_core_unit.sv
// Top level of the stack bytecode integer core.
// Holds the sequencer, operand stack, locals and array pool memories.
// Depends on sbic_pkg and sbic_alu.
//
// Each input item on the s_ channel is one instruction: opcode, first and
// second operand byte. Each item gives exactly one result item on the m_
// channel with the pc step, halt flag, top of stack, stack depth and status.
// The block works on one item at a time; s_tready is high only when idle.
// Most instructions pass through the decode, stack read, execute, pool and
// write-back states before m_tvalid rises, and a new item is taken only
// after the last result is taken. idiv and irem with a nonzero divisor wait
// in the execute state for the 32 steps of the shared divider. Instructions
// that fault, goto and return go from decode straight to the output state.
// The stack is read one word per cycle through its single memory port, which
// sets the read phase length.
// After reset the block clears the array pool, one word per cycle, all 1024
// words, and accepts no item meanwhile. Locals read as zero until written.
// When the receiver holds m_tready low, the result stays on m_tdata and no
// new item is accepted until it is taken.
module stack_bytecode_integer_core_unit import sbic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // kind, operand_hi, operand_lo
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // pc_step, halted, top_value, stack_depth, status
);

	state_t state_q, state_n;

	logic [7:0]  op_q, hi_q, lo_q;
	logic [SP_W-1:0] sp_q;
	logic [31:0] tos_q, a_q, c_q, d_q, loc_q;
	logic [15:0] step_q;
	logic        halted_q;
	logic [2:0]  status_q;

	logic [31:0] stk_mem [STACK_DEPTH];
	logic [31:0] stk_rd_q;
	logic [STK_AW-1:0] stk_raddr;

	logic [31:0] loc_mem [LOCAL_COUNT];
	logic [LOCAL_COUNT-1:0] loc_vld_q;
	logic [31:0] loc_rd_q;
	logic        loc_vrd_q;
	logic [7:0]  loc_idx, loc_idx_q;
	logic        loc_in_range;

	logic [31:0] pool_mem [POOL_WORDS];
	logic [31:0] pool_rd_q;
	logic [POOL_AW-1:0] clr_q, paddr_q;
	logic        ok_q;

	logic [POOL_AW-1:0] base_q [MAX_ARRAYS];
	logic [PF_W-1:0]    len_q [MAX_ARRAYS];
	logic [MADE_W-1:0]  made_q;
	logic [PF_W-1:0]    pool_free_q, n_q;
	logic        alloc_ok_q;

	dec_t        dec;
	logic [SP_W:0] need;
	logic        fault;
	logic [15:0] imm16;
	logic        uses_alu;

	logic        alu_start, alu_done;
	alu_op_t     alu_op;
	logic [31:0] alu_a, alu_b, alu_res;

	logic [31:0] h_sel, i_sel;
	logic [AIDX_W-1:0] hidx;
	logic [POOL_AW+1:0] psum;
	logic        arr_ok;
	logic [31:0] n32;
	logic        alloc_ok;

	logic [SP_W-1:0] new_sp;
	logic [31:0] push_val;
	logic [31:0] top_value;

	assign dec = decode(op_q);
	assign imm16 = {hi_q, lo_q};
	assign need = {1'b0, sp_q} + (SP_W + 1)'(dec.pushes) - (SP_W + 1)'(dec.pops);
	assign fault = (sp_q < SP_W'(dec.pops)) || (need > (SP_W + 1)'(STACK_DEPTH));
	assign uses_alu = (op_q == OP_IADD) || (op_q == OP_ISUB) || (op_q == OP_IMUL) ||
		(op_q == OP_IDIV) || (op_q == OP_IREM) || (op_q == OP_IINC) ||
		(op_q == OP_BRANCH_GE);

	always_comb begin
		case (op_q) inside
			[OP_LOAD_INT_0:OP_LOAD_INT_3]:   loc_idx = op_q - OP_LOAD_INT_0;
			[OP_LOAD_REF_0:OP_LOAD_REF_3]:   loc_idx = op_q - OP_LOAD_REF_0;
			[OP_STORE_INT_0:OP_STORE_INT_3]: loc_idx = op_q - OP_STORE_INT_0;
			[OP_STORE_REF_0:OP_STORE_REF_3]: loc_idx = op_q - OP_STORE_REF_0;
			default:                         loc_idx = hi_q;
		endcase
	end
	assign loc_in_range = {1'b0, loc_idx_q} < 9'(LOCAL_COUNT);

	always_comb begin
		case (state_q)
			S_DEC:   stk_raddr = STK_AW'(sp_q - SP_W'(2));
			S_RD1:   stk_raddr = STK_AW'(sp_q - SP_W'(3));
			default: stk_raddr = STK_AW'(sp_q - SP_W'(4));
		endcase
	end

	always_comb begin
		case (op_q)
			OP_ISUB:      alu_op = ALU_SUB;
			OP_IMUL:      alu_op = ALU_MUL;
			OP_IDIV:      alu_op = ALU_DIV;
			OP_IREM:      alu_op = ALU_REM;
			OP_BRANCH_GE: alu_op = ALU_CGE;
			default:      alu_op = ALU_ADD;
		endcase
		if (op_q == OP_IINC) begin
			alu_a = loc_q;
			alu_b = {{24{lo_q[7]}}, lo_q};
		end else begin
			alu_a = a_q;
			alu_b = tos_q;
		end
	end

	sbic_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.done   (alu_done),
		.result (alu_res)
	);

	always_comb begin
		if (op_q == OP_ARRAY_LOAD) begin
			h_sel = a_q;
			i_sel = tos_q;
		end else begin
			h_sel = c_q;
			i_sel = a_q;
		end
		hidx = h_sel[AIDX_W-1:0];
		psum = (POOL_AW + 2)'(base_q[hidx]) + (POOL_AW + 2)'(i_sel[PF_W-1:0]);
		arr_ok = (h_sel < 32'(made_q)) && (h_sel < 32'(MAX_ARRAYS)) &&
			(i_sel < 32'(len_q[hidx])) && (psum < (POOL_AW + 2)'(POOL_WORDS));
		n32 = tos_q[31] ? 32'd0 : tos_q;
		alloc_ok = (made_q < MADE_W'(MAX_ARRAYS)) &&
			(pool_free_q <= PF_W'(POOL_WORDS)) &&
			(n32 <= 32'(PF_W'(POOL_WORDS) - pool_free_q));
	end

	always_comb begin
		new_sp = SP_W'(sp_q + SP_W'(dec.pushes) - SP_W'(dec.pops));
		case (op_q) inside
			[OP_PUSH_CONST_LO:OP_PUSH_CONST_HI]: push_val = {24'd0, op_q} - 32'd3;
			OP_PUSH_BYTE:   push_val = {{24{hi_q[7]}}, hi_q};
			OP_PUSH_SHORT:  push_val = {{16{imm16[15]}}, imm16};
			OP_ARRAY_LOAD:  push_val = ok_q ? pool_rd_q : 32'd0;
			OP_DUP:         push_val = tos_q;
			OP_NEWARRAY:    push_val = 32'(made_q);
			OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM: push_val = alu_res;
			default:        push_val = loc_q;
		endcase
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLR:  if (clr_q == POOL_AW'(POOL_WORDS - 1)) state_n = S_IDLE;
			S_IDLE: if (s_tvalid) state_n = S_DEC;
			S_DEC: begin
				if (!dec.known || fault || op_q == OP_GOTO || op_q == OP_RETURN)
					state_n = S_OUT;
				else
					state_n = S_RD1;
			end
			S_RD1:  state_n = S_RD2;
			S_RD2:  state_n = S_RD3;
			S_RD3:  state_n = S_EXEC;
			S_EXEC: if (!uses_alu || alu_done) state_n = S_POOL;
			S_POOL: state_n = S_WB;
			S_WB:   state_n = S_OUT;
			S_OUT:  if (m_tready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		alu_start = 1'b0;
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_RD3:  alu_start = uses_alu;
			S_OUT:  m_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			sp_q <= '0;
			made_q <= '0;
			pool_free_q <= '0;
			loc_vld_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == S_CLR) clr_q <= clr_q + POOL_AW'(1);
			if (state_q == S_WB) begin
				sp_q <= new_sp;
				if ((dec.pops != 2'd0 || op_q == OP_IINC) && dec.pushes == 2'd0 &&
						op_q != OP_ARRAY_STORE && op_q != OP_BRANCH_GE && loc_in_range)
					loc_vld_q[loc_idx_q[LOC_AW-1:0]] <= 1'b1;
				if (op_q == OP_NEWARRAY && alloc_ok_q) begin
					made_q <= made_q + MADE_W'(1);
					pool_free_q <= pool_free_q + n_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		stk_rd_q <= stk_mem[stk_raddr];
		loc_rd_q <= loc_mem[loc_idx[LOC_AW-1:0]];
		loc_vrd_q <= loc_vld_q[loc_idx[LOC_AW-1:0]];
		if (state_q == S_WB && dec.pushes != 2'd0)
			stk_mem[STK_AW'(new_sp - SP_W'(1))] <= push_val;
		if (state_q == S_WB && loc_in_range && (dec.pops != 2'd0 || op_q == OP_IINC) &&
				dec.pushes == 2'd0 && op_q != OP_ARRAY_STORE && op_q != OP_BRANCH_GE)
			loc_mem[loc_idx_q[LOC_AW-1:0]] <= (op_q == OP_IINC) ? alu_res : tos_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLR)
			pool_mem[clr_q] <= 32'd0;
		else if (state_q == S_POOL && op_q == OP_ARRAY_STORE && ok_q)
			pool_mem[paddr_q] <= tos_q;
		pool_rd_q <= pool_mem[paddr_q];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q <= s_tdata[7:0];
				hi_q <= s_tdata[15:8];
				lo_q <= s_tdata[23:16];
			end
			S_DEC: begin
				loc_idx_q <= loc_idx;
				step_q <= (op_q == OP_GOTO) ? imm16 : 16'(dec.len);
				halted_q <= (op_q == OP_RETURN);
				if (!dec.known) status_q <= STS_UNKNOWN;
				else if (fault) status_q <= STS_STACK;
				else status_q <= STS_OK;
			end
			S_RD1: begin
				a_q <= stk_rd_q;
				loc_q <= (loc_vrd_q && loc_in_range) ? loc_rd_q : 32'd0;
			end
			S_RD2: c_q <= stk_rd_q;
			S_RD3: begin
				d_q <= stk_rd_q;
				ok_q <= arr_ok;
				paddr_q <= psum[POOL_AW-1:0];
				alloc_ok_q <= alloc_ok;
				n_q <= n32[PF_W-1:0];
				if ((op_q == OP_IDIV || op_q == OP_IREM) && tos_q == 32'd0)
					status_q <= STS_DIV_ZERO;
			end
			S_WB: begin
				if (op_q == OP_BRANCH_GE && alu_res[0]) step_q <= imm16;
				if (op_q == OP_NEWARRAY) begin
					if (alloc_ok_q) begin
						base_q[made_q[AIDX_W-1:0]] <= pool_free_q[POOL_AW-1:0];
						len_q[made_q[AIDX_W-1:0]] <= n_q;
					end else begin
						status_q <= STS_POOL_FULL;
					end
				end
				if (dec.pushes != 2'd0) tos_q <= push_val;
				else if (dec.pops == 2'd1) tos_q <= a_q;
				else if (dec.pops == 2'd2) tos_q <= c_q;
				else if (dec.pops == 2'd3) tos_q <= d_q;
			end
			default: ;
		endcase
	end

	assign top_value = (sp_q != '0) ? tos_q : 32'd0;
	assign m_tdata = {5'd0, status_q, 7'(sp_q), top_value, halted_q, step_q};

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result waits");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while busy");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status_q <= STS_POOL_FULL))
		else $error("undefined status code");

	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && halted_q) |-> (status_q == STS_OK && step_q == 16'd1))
		else $error("return result inconsistent");

endmodule
